[rtl/pcsm_pkg.sv]
// package for the stack machine step block
// shared widths, instruction and error codes, sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pcsm_pkg;

  localparam int unsigned STACK_DEPTH = 512;
  localparam int unsigned CODE_DEPTH  = 256;
  localparam int unsigned SAW         = $clog2(STACK_DEPTH);
  localparam int unsigned PCW         = $clog2(CODE_DEPTH);
  localparam int unsigned DW          = 32;
  localparam int unsigned LVW         = 4;

  localparam logic [LVW-1:0] MAX_LEVEL = LVW'(15);

  typedef logic [DW-1:0]  word_t;
  typedef logic [SAW-1:0] sidx_t;
  typedef logic [PCW-1:0] pc_t;

  typedef enum logic [2:0] {
    FC_LIT, FC_OPR, FC_LOD, FC_STO, FC_CAL, FC_INT, FC_JMP, FC_JPC
  } fc_e;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_RANGE, ERR_DIVZERO, ERR_TARGET
  } err_e;

  localparam word_t OPR_RET  = word_t'(0);
  localparam word_t OPR_NEG  = word_t'(1);
  localparam word_t OPR_ADD  = word_t'(2);
  localparam word_t OPR_SUB  = word_t'(3);
  localparam word_t OPR_MUL  = word_t'(4);
  localparam word_t OPR_DIV  = word_t'(5);
  localparam word_t OPR_MOD2 = word_t'(6);
  localparam word_t OPR_ODD  = word_t'(7);
  localparam word_t OPR_EQL  = word_t'(8);
  localparam word_t OPR_NEQ  = word_t'(9);
  localparam word_t OPR_LSS  = word_t'(10);
  localparam word_t OPR_LEQ  = word_t'(11);
  localparam word_t OPR_GTR  = word_t'(12);
  localparam word_t OPR_GEQ  = word_t'(13);

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_RET1, ST_RET2, ST_UNARY, ST_BIN1, ST_BIN2,
    ST_DIV, ST_JPC, ST_WALK, ST_WALK_RD, ST_WALKED, ST_LOD, ST_STO, ST_CAL2,
    ST_CAL3, ST_FIN, ST_TOPRD, ST_OUT
  } state_e;

endpackage

`default_nettype wire

[rtl/pcsm_div.sv]
// iterative signed divider, one quotient bit per cycle, truncates toward zero
// depends on pcsm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pcsm_div (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire pcsm_pkg::word_t  dividend_i,
  input  wire pcsm_pkg::word_t  divisor_i,
  output pcsm_pkg::word_t       quotient_o,
  output pcsm_pkg::div_rsp_t    rsp_o
);
  import pcsm_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [DW:0]   rem_q, rem_d;
  word_t         quo_q, quo_d;
  word_t         den_q, den_d;
  logic          neg_q, neg_d;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;

  assign rem_sh = {rem_q[DW-1:0], quo_q[DW-1]};
  assign diff   = rem_sh - {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i[DW-1] ? ('0 - dividend_i) : dividend_i;
      den_d  = divisor_i[DW-1] ? ('0 - divisor_i) : divisor_i;
      neg_d  = dividend_i[DW-1] ^ divisor_i[DW-1];
      cnt_d  = CW'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_d = diff;
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quotient_o = neg_q ? ('0 - quo_q) : quo_q;
  assign rsp_o      = '{busy: busy_q, done: done_q};

endmodule

`default_nettype wire

[rtl/pcsm_core.sv]
// empty unit, the sequencer and stack store live in the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

`default_nettype wire

[rtl/pcode_stack_machine_step.sv]
// channel | direction | handshake                 | payload
// in      | input     | in_valid_i / in_stall_o   | function_code_i, level_i, operand_i
// out     | output    | out_valid_o / out_stall_i | next_pc_o, top_value_o, top_index_o,
//         |           |                           | halted_o, error_code_o
// one instruction at a time; lod, sto and cal walk the static links, and each hop is a
// stack read in the walk and walk-read states; an error ends the sequence early
// after reset a pass over all 512 entries clears the stack store, then pc 0, base 1, top 0
// a stalled result holds the block; the next word is taken the cycle after delivery
// depends on pcsm_pkg and pcsm_div
`timescale 1ns / 1ps
`default_nettype none

module pcode_stack_machine_step (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  function_code_i,
  input  wire logic [3:0]  level_i,
  input  wire logic [31:0] operand_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       next_pc_o,
  output logic [31:0]      top_value_o,
  output logic [8:0]       top_index_o,
  output logic             halted_o,
  output logic [1:0]       error_code_o
);
  import pcsm_pkg::*;

  state_e          state_q, state_d;
  sidx_t           clr_q, clr_d;
  pc_t             pc_q, pc_d;
  sidx_t           b_q, b_d;
  sidx_t           t_q, t_d;
  logic            out_valid_q, out_valid_d;
  fc_e             fc_q, fc_d;
  word_t           a_q, a_d;
  logic [LVW-1:0]  hop_q, hop_d;
  word_t           cur_q, cur_d;
  word_t           x_q, x_d;
  sidx_t           addr_q, addr_d;
  pc_t             np_q, np_d;
  err_e            err_q, err_d;
  word_t           topv_q, topv_d;

  word_t           mem [STACK_DEPTH];
  word_t           rd_q;
  logic            mem_we;
  sidx_t           mem_waddr;
  word_t           mem_wdata;
  sidx_t           mem_raddr;

  logic            div_start;
  word_t           div_quo;
  div_rsp_t        div_rsp;

  sidx_t           t_inc, t_dec;
  logic            t_full, t_empty;
  logic [DW:0]     int_sum, idx_sum;
  logic            int_ok, idx_ok;
  logic            a_in_code, cur_in_stack;
  logic [SAW:0]    t_plus3, b_plus2;
  word_t           bin_res, un_res;

  pcsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_q),
    .divisor_i  (rd_q),
    .quotient_o (div_quo),
    .rsp_o      (div_rsp)
  );

  assign t_inc        = t_q + sidx_t'(1);
  assign t_dec        = t_q - sidx_t'(1);
  assign t_full       = (t_q == '1);
  assign t_empty      = (t_q == '0);
  assign int_sum      = {{(DW + 1 - SAW){1'b0}}, t_q} + {a_q[DW-1], a_q};
  assign idx_sum      = {cur_q[DW-1], cur_q} + {a_q[DW-1], a_q};
  assign int_ok       = (int_sum[DW:SAW] == '0);
  assign idx_ok       = (idx_sum[DW:SAW] == '0);
  assign a_in_code    = (a_q[DW-1:PCW] == '0);
  assign cur_in_stack = (cur_q[DW-1:SAW] == '0);
  assign t_plus3      = {1'b0, t_q} + (SAW + 1)'(3);
  assign b_plus2      = {1'b0, b_q} + (SAW + 1)'(2);

  always_comb begin
    case (a_q)
      OPR_ADD: bin_res = x_q + rd_q;
      OPR_SUB: bin_res = x_q - rd_q;
      OPR_MUL: bin_res = x_q * rd_q;
      OPR_EQL: bin_res = word_t'(x_q == rd_q);
      OPR_NEQ: bin_res = word_t'(x_q != rd_q);
      OPR_LSS: bin_res = word_t'($signed(x_q) < $signed(rd_q));
      OPR_LEQ: bin_res = word_t'($signed(x_q) <= $signed(rd_q));
      OPR_GTR: bin_res = word_t'($signed(x_q) > $signed(rd_q));
      OPR_GEQ: bin_res = word_t'($signed(x_q) >= $signed(rd_q));
      default: bin_res = '0;
    endcase
  end

  always_comb begin
    case (a_q)
      OPR_NEG:  un_res = '0 - rd_q;
      OPR_MOD2: un_res = rd_q[0] ? (rd_q[DW-1] ? '1 : word_t'(1)) : '0;
      default:  un_res = word_t'(rd_q[0]);
    endcase
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pc_d        = pc_q;
    b_d         = b_q;
    t_d         = t_q;
    out_valid_d = out_valid_q;
    fc_d        = fc_q;
    a_d         = a_q;
    hop_d       = hop_q;
    cur_d       = cur_q;
    x_d         = x_q;
    addr_d      = addr_q;
    np_d        = np_q;
    err_d       = err_q;
    topv_d      = topv_q;
    mem_we      = 1'b0;
    mem_waddr   = t_q;
    mem_wdata   = '0;
    mem_raddr   = t_q;
    div_start   = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + sidx_t'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          fc_d    = fc_e'(function_code_i);
          a_d     = operand_i;
          hop_d   = (level_i > MAX_LEVEL) ? MAX_LEVEL : level_i;
          cur_d   = word_t'(b_q);
          np_d    = pc_q + pc_t'(1);
          err_d   = ERR_NONE;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_FIN;
        case (fc_q)
          FC_LIT: begin
            if (t_full) begin
              err_d = ERR_RANGE;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = t_inc;
              mem_wdata = a_q;
              t_d       = t_inc;
            end
          end
          FC_OPR: begin
            case (a_q) inside
              OPR_RET: begin
                if (b_q == '0 || b_plus2[SAW]) begin
                  err_d = ERR_RANGE;
                end else begin
                  mem_raddr = b_q + sidx_t'(1);
                  state_d   = ST_RET1;
                end
              end
              OPR_NEG, OPR_MOD2, OPR_ODD: begin
                state_d = ST_UNARY;
              end
              [OPR_ADD:OPR_DIV], [OPR_EQL:OPR_GEQ]: begin
                if (t_empty) begin
                  err_d = ERR_RANGE;
                end else begin
                  mem_raddr = t_dec;
                  state_d   = ST_BIN1;
                end
              end
              default: begin
                state_d = ST_FIN;
              end
            endcase
          end
          FC_LOD, FC_STO, FC_CAL: begin
            state_d = ST_WALK;
          end
          FC_INT: begin
            if (int_ok) begin
              t_d = int_sum[SAW-1:0];
            end else begin
              err_d = ERR_RANGE;
            end
          end
          FC_JMP: begin
            if (a_in_code) begin
              np_d = a_q[PCW-1:0];
            end else begin
              err_d = ERR_TARGET;
            end
          end
          default: begin
            if (t_empty) begin
              err_d = ERR_RANGE;
            end else begin
              state_d = ST_JPC;
            end
          end
        endcase
      end
      ST_RET1: begin
        x_d       = rd_q;
        mem_raddr = b_q + sidx_t'(2);
        state_d   = ST_RET2;
      end
      ST_RET2: begin
        state_d = ST_FIN;
        if (x_q[DW-1:SAW] != '0) begin
          err_d = ERR_RANGE;
        end else if (rd_q[DW-1:PCW] != '0) begin
          err_d = ERR_TARGET;
        end else begin
          t_d  = b_q - sidx_t'(1);
          b_d  = x_q[SAW-1:0];
          np_d = rd_q[PCW-1:0];
        end
      end
      ST_UNARY: begin
        mem_we    = 1'b1;
        mem_wdata = un_res;
        state_d   = ST_FIN;
      end
      ST_BIN1: begin
        x_d     = rd_q;
        state_d = ST_BIN2;
      end
      ST_BIN2: begin
        if (a_q == OPR_DIV) begin
          if (rd_q == '0) begin
            err_d   = ERR_DIVZERO;
            state_d = ST_FIN;
          end else begin
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end else begin
          mem_we    = 1'b1;
          mem_waddr = t_dec;
          mem_wdata = bin_res;
          t_d       = t_dec;
          state_d   = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          mem_we    = 1'b1;
          mem_waddr = t_dec;
          mem_wdata = div_quo;
          t_d       = t_dec;
          state_d   = ST_FIN;
        end
      end
      ST_JPC: begin
        state_d = ST_FIN;
        if (rd_q == '0 && !a_in_code) begin
          err_d = ERR_TARGET;
        end else begin
          if (rd_q == '0) begin
            np_d = a_q[PCW-1:0];
          end
          t_d = t_dec;
        end
      end
      ST_WALK: begin
        if (hop_q == '0) begin
          state_d = ST_WALKED;
        end else if (!cur_in_stack) begin
          err_d   = ERR_RANGE;
          state_d = ST_FIN;
        end else begin
          mem_raddr = cur_q[SAW-1:0];
          state_d   = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        cur_d   = rd_q;
        hop_d   = hop_q - LVW'(1);
        state_d = ST_WALK;
      end
      ST_WALKED: begin
        state_d = ST_FIN;
        case (fc_q)
          FC_LOD: begin
            if (!idx_ok || t_full) begin
              err_d = ERR_RANGE;
            end else begin
              mem_raddr = idx_sum[SAW-1:0];
              state_d   = ST_LOD;
            end
          end
          FC_STO: begin
            if (!idx_ok || t_empty) begin
              err_d = ERR_RANGE;
            end else begin
              addr_d  = idx_sum[SAW-1:0];
              state_d = ST_STO;
            end
          end
          default: begin
            if (t_plus3[SAW]) begin
              err_d = ERR_RANGE;
            end else if (!a_in_code) begin
              err_d = ERR_TARGET;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = t_inc;
              mem_wdata = cur_q;
              state_d   = ST_CAL2;
            end
          end
        endcase
      end
      ST_LOD: begin
        mem_we    = 1'b1;
        mem_waddr = t_inc;
        mem_wdata = rd_q;
        t_d       = t_inc;
        state_d   = ST_FIN;
      end
      ST_STO: begin
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = rd_q;
        t_d       = t_dec;
        state_d   = ST_FIN;
      end
      ST_CAL2: begin
        mem_we    = 1'b1;
        mem_waddr = t_q + sidx_t'(2);
        mem_wdata = word_t'(b_q);
        state_d   = ST_CAL3;
      end
      ST_CAL3: begin
        mem_we    = 1'b1;
        mem_waddr = t_plus3[SAW-1:0];
        mem_wdata = word_t'(np_q);
        b_d       = t_inc;
        np_d      = a_q[PCW-1:0];
        state_d   = ST_FIN;
      end
      ST_FIN: begin
        pc_d    = np_q;
        state_d = ST_TOPRD;
      end
      ST_TOPRD: begin
        topv_d      = rd_q;
        out_valid_d = 1'b1;
        state_d     = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          out_valid_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      pc_q        <= '0;
      b_q         <= sidx_t'(1);
      t_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pc_q        <= pc_d;
      b_q         <= b_d;
      t_q         <= t_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fc_q   <= fc_d;
    a_q    <= a_d;
    hop_q  <= hop_d;
    cur_q  <= cur_d;
    x_q    <= x_d;
    addr_q <= addr_d;
    np_q   <= np_d;
    err_q  <= err_d;
    topv_q <= topv_d;
  end

  // stack store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[mem_raddr];
  end

  assign in_stall_o   = (state_q != ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign next_pc_o    = pc_q;
  assign top_value_o  = topv_q;
  assign top_index_o  = t_q;
  assign halted_o     = (pc_q == '0);
  assign error_code_o = err_q;

`ifndef SYNTH
  a_out_holds_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("word accepted while a result is pending");
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_DECODE))
    else $error("accepted word not decoded");
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide step");
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.busy |-> (state_q == ST_DIV))
    else $error("divider running outside divide step");
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (!out_valid_o && in_stall_o))
    else $error("activity during clearing pass");
`endif

endmodule

`default_nettype wire

[bench/pcode_stack_machine_step_tb.sv]
// testbench for the stack machine step block: directed and random instructions
// checked word by word against a behavioral predictor of stack, pc, base and top
// depends on pcsm_pkg and pcode_stack_machine_step
`timescale 1ns / 1ps

module pcode_stack_machine_step_tb;
  import pcsm_pkg::*;

  typedef struct {
    pc_t   next_pc;
    word_t top_value;
    sidx_t top_index;
    logic  halted;
    err_e  error_code;
  } step_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  function_code_i;
  logic [3:0]  level_i;
  logic [31:0] operand_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  next_pc_o;
  logic [31:0] top_value_o;
  logic [8:0]  top_index_o;
  logic        halted_o;
  logic [1:0]  error_code_o;

  word_t        stack_mem [STACK_DEPTH];
  longint       pc_q;
  longint       base_q;
  longint       top_q;
  step_result_t pending_results[$];
  int           mismatch_count;
  int           long_hold_cycles;
  bit           no_idle;

  pcode_stack_machine_step dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .function_code_i(function_code_i), .level_i(level_i), .operand_i(operand_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .next_pc_o(next_pc_o), .top_value_o(top_value_o), .top_index_o(top_index_o),
    .halted_o(halted_o), .error_code_o(error_code_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint sext(word_t w);
    return longint'($signed(w));
  endfunction

  function automatic bit in_stack(longint i);
    return i >= 0 && i < longint'(STACK_DEPTH);
  endfunction

  function automatic bit in_code(longint i);
    return i >= 0 && i < longint'(CODE_DEPTH);
  endfunction

  function automatic step_result_t execute_instruction(fc_e fc, logic [3:0] lv, word_t op);
    longint a, t, b, np, bs, x, y, r, nb, ra;
    int hops;
    bit walk_ok;
    err_e err;
    step_result_t res;
    a = sext(op);
    t = top_q;
    b = base_q;
    np = (pc_q + 1) % longint'(CODE_DEPTH);
    err = ERR_NONE;
    hops = (lv > MAX_LEVEL) ? int'(MAX_LEVEL) : int'(lv);
    // static link walk
    walk_ok = 1'b1;
    bs = b;
    for (int k = 0; k < hops; k++) begin
      if (walk_ok) begin
        if (!in_stack(bs)) walk_ok = 1'b0;
        else bs = sext(stack_mem[bs]);
      end
    end
    case (fc)
      FC_LIT: begin
        if (!in_stack(t + 1)) err = ERR_RANGE;
        else begin stack_mem[t + 1] = op; t++; end
      end
      FC_OPR: begin
        case (op)
          OPR_RET: begin
            if (b < 1 || !in_stack(b + 2)) err = ERR_RANGE;
            else begin
              nb = sext(stack_mem[b + 1]);
              ra = sext(stack_mem[b + 2]);
              if (!in_stack(nb)) err = ERR_RANGE;
              else if (!in_code(ra)) err = ERR_TARGET;
              else begin t = b - 1; b = nb; np = ra; end
            end
          end
          OPR_NEG:  stack_mem[t] = word_t'(0) - stack_mem[t];
          OPR_MOD2: stack_mem[t] = word_t'(sext(stack_mem[t]) % 2);
          OPR_ODD:  stack_mem[t] = stack_mem[t] & word_t'(1);
          OPR_ADD, OPR_SUB, OPR_MUL, OPR_DIV, OPR_EQL, OPR_NEQ,
          OPR_LSS, OPR_LEQ, OPR_GTR, OPR_GEQ: begin
            if (t < 1) err = ERR_RANGE;
            else begin
              x = sext(stack_mem[t - 1]);
              y = sext(stack_mem[t]);
              case (op)
                OPR_ADD: r = x + y;
                OPR_SUB: r = x - y;
                OPR_MUL: r = x * y;
                OPR_DIV: r = (y == 0) ? 0 : x / y;
                OPR_EQL: r = (x == y);
                OPR_NEQ: r = (x != y);
                OPR_LSS: r = (x < y);
                OPR_LEQ: r = (x <= y);
                OPR_GTR: r = (x > y);
                default: r = (x >= y);
              endcase
              if (op == OPR_DIV && y == 0) err = ERR_DIVZERO;
              else begin stack_mem[t - 1] = word_t'(r); t--; end
            end
          end
          default: ;
        endcase
      end
      FC_LOD: begin
        if (!walk_ok || !in_stack(bs + a) || !in_stack(t + 1)) err = ERR_RANGE;
        else begin stack_mem[t + 1] = stack_mem[bs + a]; t++; end
      end
      FC_STO: begin
        if (!walk_ok || !in_stack(bs + a) || t < 1) err = ERR_RANGE;
        else begin stack_mem[bs + a] = stack_mem[t]; t--; end
      end
      FC_CAL: begin
        if (!walk_ok || !in_stack(t + 3)) err = ERR_RANGE;
        else if (!in_code(a)) err = ERR_TARGET;
        else begin
          stack_mem[t + 1] = word_t'(bs);
          stack_mem[t + 2] = word_t'(b);
          stack_mem[t + 3] = word_t'(np);
          b = t + 1;
          np = a;
        end
      end
      FC_INT: begin
        if (!in_stack(t + a)) err = ERR_RANGE;
        else t += a;
      end
      FC_JMP: begin
        if (!in_code(a)) err = ERR_TARGET;
        else np = a;
      end
      default: begin
        if (t < 1) err = ERR_RANGE;
        else if (stack_mem[t] == '0 && !in_code(a)) err = ERR_TARGET;
        else begin
          if (stack_mem[t] == '0) np = a;
          t--;
        end
      end
    endcase
    top_q = t;
    base_q = b;
    pc_q = np;
    res.next_pc = pc_t'(pc_q);
    res.top_value = stack_mem[top_q];
    res.top_index = sidx_t'(top_q);
    res.halted = (pc_q == 0);
    res.error_code = err;
    return res;
  endfunction

  task automatic send_word(fc_e fc, logic [3:0] lv, word_t op);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    function_code_i <= fc;
    level_i <= lv;
    operand_i <= op;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(execute_instruction(fc, lv, op));
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    if (in_valid_i) in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (60) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    step_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result word pc=%0d", next_pc_o);
      end else begin
        want = pending_results.pop_front();
        if (next_pc_o !== want.next_pc || top_value_o !== want.top_value ||
            top_index_o !== want.top_index || halted_o !== want.halted ||
            error_code_o !== want.error_code) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch exp pc=%0d val=%h idx=%0d halt=%0d err=%0d, got pc=%0d val=%h idx=%0d halt=%0d err=%0d",
                     want.next_pc, want.top_value, want.top_index, want.halted,
                     want.error_code, next_pc_o, top_value_o, top_index_o, halted_o,
                     error_code_o);
        end
      end
    end
  end

  // receiver stall
  initial begin
    int n;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (long_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (long_hold_cycles) @(posedge clk_i);
        long_hold_cycles = 0;
      end
      n = no_idle ? 0 : $urandom_range(0, 3);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic test_arithmetic;
    send_word(FC_LIT, 4'd0, 32'h7fff_ffff);
    send_word(FC_LIT, 4'd0, 32'h8000_0000);
    send_word(FC_OPR, 4'd0, OPR_ADD);
    send_word(FC_OPR, 4'd0, OPR_NEG);
    send_word(FC_LIT, 4'd0, 32'hffff_fffd);
    for (int k = 3; k <= 13; k++) begin
      send_word(FC_LIT, 4'd0, word_t'($urandom_range(0, 9)));
      send_word(FC_OPR, 4'd0, word_t'(k));
    end
    send_word(FC_OPR, 4'd0, OPR_MOD2);
    send_word(FC_OPR, 4'd0, OPR_ODD);
    send_word(FC_LIT, 4'd0, 32'd0);
    send_word(FC_OPR, 4'd0, OPR_DIV);
    send_word(FC_LIT, 4'd0, 32'h8000_0000);
    send_word(FC_LIT, 4'd0, 32'hffff_ffff);
    send_word(FC_OPR, 4'd0, OPR_DIV);
    send_word(FC_OPR, 4'd0, 32'd99);
  endtask

  task automatic test_frames_and_branches;
    send_word(FC_INT, 4'd0, 32'd3);
    send_word(FC_CAL, 4'd0, 32'd40);
    send_word(FC_INT, 4'd0, 32'd4);
    send_word(FC_LIT, 4'd0, 32'd77);
    send_word(FC_STO, 4'd1, 32'd2);
    send_word(FC_LOD, 4'd15, 32'd0);
    send_word(FC_CAL, 4'd1, 32'd300);
    send_word(FC_OPR, 4'd0, OPR_RET);
    send_word(FC_JMP, 4'd0, 32'd255);
    send_word(FC_JMP, 4'd0, 32'hffff_ffff);
    send_word(FC_LIT, 4'd0, 32'd0);
    send_word(FC_JPC, 4'd0, 32'd1000);
    send_word(FC_JPC, 4'd0, 32'd0);
    send_word(FC_LIT, 4'd0, 32'd5);
    send_word(FC_JPC, 4'd0, 32'd20);
    send_word(FC_INT, 4'd0, 32'd600);
    send_word(FC_INT, 4'd0, 32'h8000_0000);
    send_word(FC_JPC, 4'd0, 32'd3);
    send_word(FC_INT, 4'd0, 32'd508);
    send_word(FC_LIT, 4'd0, 32'd1);
    send_word(FC_LIT, 4'd0, 32'd2);
    send_word(FC_CAL, 4'd0, 32'd7);
    send_word(FC_INT, 4'd0, 32'hffff_fe04);
  endtask

  task automatic send_random_word;
    fc_e fc;
    logic [3:0] lv;
    word_t op;
    int pick;
    fc = fc_e'($urandom_range(0, 7));
    lv = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
    pick = $urandom_range(0, 19);
    if (pick == 0) op = $urandom;
    else begin
      case (fc)
        FC_LIT:         op = (pick < 4) ? $urandom : word_t'($urandom_range(0, 20));
        FC_OPR:         op = word_t'((pick < 6) ? 0 : $urandom_range(1, 14));
        FC_LOD, FC_STO: op = word_t'($signed($urandom_range(0, 8)) - 2);
        FC_INT:         op = word_t'($signed($urandom_range(0, 12)) - 6);
        default:        op = word_t'($urandom_range(0, 260));
      endcase
    end
    send_word(fc, lv, op);
  endtask

  task automatic test_random_programs;
    for (int k = 0; k < 460; k++) begin
      no_idle = (k >= 200 && k < 260);
      send_random_word();
    end
    no_idle = 1'b0;
  endtask

  task automatic test_backpressure;
    long_hold_cycles = 300;
    for (int k = 0; k < 12; k++) send_random_word();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    function_code_i = '0;
    level_i = '0;
    operand_i = '0;
    mismatch_count = 0;
    long_hold_cycles = 0;
    no_idle = 1'b0;
    foreach (stack_mem[k]) stack_mem[k] = '0;
    pc_q = 0;
    base_q = 1;
    top_q = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_arithmetic();
    test_frames_and_branches();
    test_random_programs();
    test_backpressure();
    drain();
    if (mismatch_count == 0 && pending_results.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
